### hdl/sha1_hash_engine_top_defines.svh
// Assertion macros for the hash engine.
// Each one checks on the rising edge of clk and stays quiet while rst is high.
`ifndef SHA1_HASH_ENGINE_TOP_DEFINES_SVH
`define SHA1_HASH_ENGINE_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define SHA1HE_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sha1 engine check failed");
// Next-cycle implication.
`define SHA1HE_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sha1 engine check failed");
`else
`define SHA1HE_ASSERT_IMP(label, ante, cons)
`define SHA1HE_ASSERT_NXT(label, ante, cons)
`endif

`endif

### hdl/sha1he_pkg.sv
`default_nettype none

package sha1he_pkg;

  localparam int ROUND_COUNT = 80;
  localparam int BLOCK_WORDS = 16;
  localparam int POS_W       = $clog2(BLOCK_WORDS);
  localparam int DIGEST_WORDS = 5;

  // Initial chaining value
  localparam logic [31:0] H_INIT [DIGEST_WORDS] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  // Round constants, one per group of twenty rounds
  localparam logic [31:0] K_0 = 32'h5A827999;
  localparam logic [31:0] K_1 = 32'h6ED9EBA1;
  localparam logic [31:0] K_2 = 32'h8F1BBCDC;
  localparam logic [31:0] K_3 = 32'hCA62C1D6;

  localparam logic [31:0] MARKER_WORD = 32'h80000000;
  localparam logic [7:0]  MARKER_BYTE = 8'h80;
  localparam logic [2:0]  FULL_BYTES  = 3'd4;
  localparam logic [2:0]  LAST_INDEX  = 3'(DIGEST_WORDS - 1);

  // Sequencer states
  typedef enum logic [4:0] {
    S_LOAD  = 5'b00001,
    S_ROUND = 5'b00010,
    S_PAD   = 5'b00100,
    S_ADD   = 5'b01000,
    S_OUT   = 5'b10000
  } state_t;

  // Clear the unused bytes of a short final word and place the marker byte
  function automatic logic [31:0] pad_last_word(input logic [31:0] w, input logic [1:0] nb);
    logic [31:0] r;
    case (nb)
      2'd0:    r = MARKER_WORD;
      2'd1:    r = {w[31:24], MARKER_BYTE, 16'h0000};
      2'd2:    r = {w[31:16], MARKER_BYTE, 8'h00};
      2'd3:    r = {w[31:8], MARKER_BYTE};
      default: r = MARKER_WORD;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

### hdl/sha1_hash_engine_top.sv
// Each message word is taken on an in_fire handshake; every full 64-byte block then runs
// its rounds through the single shared round adder, followed by a chaining-add step.
// No new message word is accepted while a block is in its rounds or its chaining add.
// Final word: padding words and one or two blocks, then five
// digest words, one per accepted output cycle.
// Reset (rst, synchronous): chaining words to the initial value, counters and length cleared.
`default_nettype none
`include "sha1_hash_engine_top_defines.svh"

module sha1_hash_engine_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] message_word,
  input  wire logic [2:0]  valid_bytes,
  input  wire logic        last_word,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [31:0]      digest_word,
  output logic [2:0]       word_index,
  output logic             digest_done
);

  localparam int PW = sha1he_pkg::POS_W;

  sha1he_pkg::state_t state, state_next;

  logic [31:0]   chain [sha1he_pkg::DIGEST_WORDS];
  logic [31:0]   ra, rb, rc, rd, re;
  logic [31:0]   w_line [sha1he_pkg::BLOCK_WORDS];
  logic [6:0]    round_count;
  logic [PW-1:0] word_pos;
  logic [63:0]   bit_length;
  logic          final_mode;
  logic          pend_marker;
  logic          len_hi_sent;
  logic          len_done;
  logic [2:0]    out_index;

  logic          in_fire, out_fire;
  logic          push_en, wrap;
  logic [31:0]   push_word;
  logic [2:0]    vb_eff;
  logic [5:0]    len_add;
  logic [31:0]   f_val, k_val, w_new, tmp;
  logic          last_round, out_last;

  // Handshake
  assign in_ready  = (state == sha1he_pkg::S_LOAD);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = (state == sha1he_pkg::S_OUT);
  assign out_fire  = out_valid && out_ready;
  assign out_last  = (out_index == sha1he_pkg::LAST_INDEX);

  assign digest_word = chain[out_index];
  assign word_index  = out_index;
  assign digest_done = out_last;

  // Clamp the byte count of the final word
  assign vb_eff  = (valid_bytes > sha1he_pkg::FULL_BYTES) ? sha1he_pkg::FULL_BYTES : valid_bytes;
  assign len_add = last_word ? {vb_eff, 3'b000} : 6'd32;

  // Select the word that enters the schedule line
  always_comb begin
    push_en   = 1'b0;
    push_word = '0;
    if (state == sha1he_pkg::S_LOAD) begin
      push_en = in_fire;
      if (last_word && (vb_eff != sha1he_pkg::FULL_BYTES)) begin
        push_word = sha1he_pkg::pad_last_word(message_word, vb_eff[1:0]);
      end else begin
        push_word = message_word;
      end
    end else if (state == sha1he_pkg::S_PAD) begin
      push_en = 1'b1;
      if (pend_marker) begin
        push_word = sha1he_pkg::MARKER_WORD;
      end else if (len_hi_sent) begin
        push_word = bit_length[31:0];
      end else if (word_pos == PW'(sha1he_pkg::BLOCK_WORDS - 2)) begin
        push_word = bit_length[63:32];
      end else begin
        push_word = '0;
      end
    end
  end

  assign wrap = push_en && (word_pos == PW'(sha1he_pkg::BLOCK_WORDS - 1));

  // Round function and constant by round group
  always_comb begin
    case (round_count) inside
      [7'd0:7'd19]: begin
        f_val = (rb & rc) | (~rb & rd);
        k_val = sha1he_pkg::K_0;
      end
      [7'd20:7'd39]: begin
        f_val = rb ^ rc ^ rd;
        k_val = sha1he_pkg::K_1;
      end
      [7'd40:7'd59]: begin
        f_val = (rb & rc) | (rb & rd) | (rc & rd);
        k_val = sha1he_pkg::K_2;
      end
      default: begin
        f_val = rb ^ rc ^ rd;
        k_val = sha1he_pkg::K_3;
      end
    endcase
  end

  assign w_new      = w_line[13] ^ w_line[8] ^ w_line[2] ^ w_line[0];
  assign tmp        = {ra[26:0], ra[31:27]} + f_val + re + k_val + w_line[0];
  assign last_round = (round_count == 7'(sha1he_pkg::ROUND_COUNT - 1));

  // Sequencer
  always_comb begin
    state_next = state;
    case (state)
      sha1he_pkg::S_LOAD: begin
        if (in_fire) begin
          if (wrap) begin
            state_next = sha1he_pkg::S_ROUND;
          end else if (last_word) begin
            state_next = sha1he_pkg::S_PAD;
          end
        end
      end
      sha1he_pkg::S_PAD: begin
        if (wrap) begin
          state_next = sha1he_pkg::S_ROUND;
        end
      end
      sha1he_pkg::S_ROUND: begin
        if (last_round) begin
          state_next = sha1he_pkg::S_ADD;
        end
      end
      sha1he_pkg::S_ADD: begin
        if (len_done) begin
          state_next = sha1he_pkg::S_OUT;
        end else if (final_mode) begin
          state_next = sha1he_pkg::S_PAD;
        end else begin
          state_next = sha1he_pkg::S_LOAD;
        end
      end
      sha1he_pkg::S_OUT: begin
        if (out_fire && out_last) begin
          state_next = sha1he_pkg::S_LOAD;
        end
      end
      default: state_next = sha1he_pkg::S_LOAD;
    endcase
  end

  // Control state and chaining words
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= sha1he_pkg::S_LOAD;
      round_count <= '0;
      word_pos    <= '0;
      bit_length  <= '0;
      final_mode  <= 1'b0;
      pend_marker <= 1'b0;
      len_hi_sent <= 1'b0;
      len_done    <= 1'b0;
      out_index   <= '0;
      for (int i = 0; i < sha1he_pkg::DIGEST_WORDS; i++) begin
        chain[i] <= sha1he_pkg::H_INIT[i];
      end
    end else begin
      state <= state_next;

      // Advance the fill position
      if (push_en) begin
        word_pos <= word_pos + PW'(1);
      end

      // Count message length and note the final word
      if (in_fire) begin
        bit_length <= bit_length + {58'd0, len_add};
        if (last_word) begin
          final_mode  <= 1'b1;
          pend_marker <= (vb_eff == sha1he_pkg::FULL_BYTES);
        end
      end

      // Track padding progress
      if (state == sha1he_pkg::S_PAD) begin
        if (pend_marker) begin
          pend_marker <= 1'b0;
        end else if (len_hi_sent) begin
          len_hi_sent <= 1'b0;
          len_done    <= 1'b1;
        end else if (word_pos == PW'(sha1he_pkg::BLOCK_WORDS - 2)) begin
          len_hi_sent <= 1'b1;
        end
      end

      // Step the round counter
      if (state == sha1he_pkg::S_ROUND) begin
        round_count <= last_round ? 7'd0 : round_count + 7'd1;
      end

      // Fold the working words into the chain
      if (state == sha1he_pkg::S_ADD) begin
        chain[0] <= chain[0] + ra;
        chain[1] <= chain[1] + rb;
        chain[2] <= chain[2] + rc;
        chain[3] <= chain[3] + rd;
        chain[4] <= chain[4] + re;
      end

      // Hand out digest words, then drop back to the initial state
      if (out_fire) begin
        if (out_last) begin
          out_index  <= '0;
          bit_length <= '0;
          final_mode <= 1'b0;
          len_done   <= 1'b0;
          word_pos   <= '0;
          for (int i = 0; i < sha1he_pkg::DIGEST_WORDS; i++) begin
            chain[i] <= sha1he_pkg::H_INIT[i];
          end
        end else begin
          out_index <= out_index + 3'd1;
        end
      end
    end
  end

  // Working words: load from the chain when a block completes, then run rounds
  always_ff @(posedge clk) begin
    if (wrap) begin
      ra <= chain[0];
      rb <= chain[1];
      rc <= chain[2];
      rd <= chain[3];
      re <= chain[4];
    end else if (state == sha1he_pkg::S_ROUND) begin
      ra <= tmp;
      rb <= ra;
      rc <= {rb[1:0], rb[31:2]};
      rd <= rc;
      re <= rd;
    end
  end

  // Schedule line: shift in message words, or the expanded word during rounds
  always_ff @(posedge clk) begin
    if (push_en || (state == sha1he_pkg::S_ROUND)) begin
      for (int i = 0; i < sha1he_pkg::BLOCK_WORDS - 1; i++) begin
        w_line[i] <= w_line[i + 1];
      end
      w_line[sha1he_pkg::BLOCK_WORDS - 1] <= push_en ? push_word : {w_new[30:0], w_new[31]};
    end
  end

  // Checks
  `SHA1HE_ASSERT_IMP(a_no_in_during_out, in_ready, !out_valid)
  `SHA1HE_ASSERT_IMP(a_round_idle_zero, round_count != 7'd0, state == sha1he_pkg::S_ROUND)
  `SHA1HE_ASSERT_IMP(a_add_after_round, state == sha1he_pkg::S_ADD, $past(state) == sha1he_pkg::S_ROUND)
  `SHA1HE_ASSERT_NXT(a_ready_after_digest, out_valid && out_ready && digest_done, in_ready && word_pos == '0)

endmodule

`default_nettype wire
